/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* rtl/kpd_pkg.sv */
// ---------------------------------------------------------------------------
// kpd_pkg
// Types and constants shared by the keypad scan and debounce modules.
// ---------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;
  localparam int CODE_W   = 5;
  localparam int IDX_W    = 4;

  localparam logic [CODE_W-1:0] KEY_NONE = 5'd0;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd20;

  // Printed-key code for each matrix bit, bit row*4+col.
  localparam logic [CODE_W-1:0] KEY_TABLE [SAMPLE_W] = '{
    5'd14, 5'd13, 5'd12, 5'd11,
    5'd16, 5'd10, 5'd7,  5'd4,
    5'd1,  5'd9,  5'd6,  5'd3,
    5'd15, 5'd8,  5'd5,  5'd2
  };

  typedef struct packed {
    logic              reported;
    logic [CODE_W-1:0] code;
  } kpd_result_t;

endpackage

`default_nettype wire

/* rtl/keypad_scan_debounce.sv */
// ---------------------------------------------------------------------------
// keypad_scan_debounce
// 4x4 matrix keypad poll decoder with time-based debounce.
// ---------------------------------------------------------------------------
// Each poll transfer carries a full active-low matrix sample and a ms
// timestamp, and yields exactly one result transfer. A poll is taken every
// clock unless the result side stalls. A result passes through the input
// register and then the result register, which loads together with the
// debounce state. Backpressure on the result side stalls the chain, while
// the input register still absorbs one more poll. debounce_ms resets to 20
// and is written through cfg_valid/cfg_data; the user must write it only
// while no poll is in flight, as the block itself does not enforce this.
`default_nettype none

module keypad_scan_debounce (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [15:0] matrix_sample, [47:16] now_ms
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // [4:0] key_code, [7:5] zero
  output logic             m_tuser,   // [0] key_reported
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data   // debounce_ms
);
  import kpd_pkg::*;

  logic                stage_valid;
  logic [SAMPLE_W-1:0] stage_sample;
  logic [TIME_W-1:0]   stage_now;
  logic [DEB_W-1:0]    debounce_ms;
  logic [CODE_W-1:0]   raw_key;
  logic                item_take;
  kpd_result_t         result;

  assign cfg_ready = 1'b1;
  assign s_tready  = !stage_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      debounce_ms <= DEBOUNCE_RESET;
    end else begin
      if (s_tvalid && s_tready) begin
        stage_valid <= 1'b1;
      end else if (item_take) begin
        stage_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        debounce_ms <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_sample <= s_tdata[SAMPLE_W-1:0];
      stage_now    <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
    end
  end

  kpd_encode u_encode (
    .sample  (stage_sample),
    .raw_key (raw_key)
  );

  kpd_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (stage_valid),
    .raw_key      (raw_key),
    .now_ms       (stage_now),
    .debounce_ms  (debounce_ms),
    .item_take    (item_take),
    .result_valid (m_tvalid),
    .result_ready (m_tready),
    .result       (result)
  );

  assign m_tdata = {3'b000, result.code};
  assign m_tuser = result.reported;

endmodule

`default_nettype wire

/* rtl/kpd_encode.sv */
// ---------------------------------------------------------------------------
// kpd_encode
// Priority encoder over the active-low matrix sample and keycap mapping.
// ---------------------------------------------------------------------------
`default_nettype none

module kpd_encode (
  input  wire logic [kpd_pkg::SAMPLE_W-1:0] sample,
  output logic      [kpd_pkg::CODE_W-1:0]   raw_key
);
  import kpd_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             found;

  // Lowest pressed bit wins.
  always_comb begin
    idx   = '0;
    found = 1'b0;
    for (int i = SAMPLE_W - 1; i >= 0; i--) begin
      if (!sample[i]) begin
        idx   = IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  assign raw_key = found ? KEY_TABLE[idx] : KEY_NONE;

endmodule

`default_nettype wire

/* rtl/kpd_debounce.sv */
// ---------------------------------------------------------------------------
// kpd_debounce
// Debounce state, report decision and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module kpd_debounce (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  input  wire logic [kpd_pkg::CODE_W-1:0]   raw_key,
  input  wire logic [kpd_pkg::TIME_W-1:0]   now_ms,
  input  wire logic [kpd_pkg::DEB_W-1:0]    debounce_ms,
  output logic                              item_take,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output kpd_pkg::kpd_result_t              result
);
  import kpd_pkg::*;

  logic [CODE_W-1:0] previous_raw_key;
  logic [CODE_W-1:0] last_reported_key;
  logic [TIME_W-1:0] last_change_time;

  logic              changed;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] elapsed;
  logic              stable;
  logic              report;

  assign item_take = item_valid && (!result_valid || result_ready);

  assign changed   = raw_key != previous_raw_key;
  assign base_time = changed ? now_ms : last_change_time;
  assign elapsed   = now_ms - base_time;
  assign stable    = elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms};
  assign report    = stable && (raw_key != KEY_NONE) && (raw_key != last_reported_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw_key  <= KEY_NONE;
      last_reported_key <= KEY_NONE;
      last_change_time  <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (item_take) begin
        previous_raw_key <= raw_key;
        if (changed) begin
          last_change_time <= now_ms;
        end
        if (stable && raw_key == KEY_NONE) begin
          last_reported_key <= KEY_NONE;
        end else if (report) begin
          last_reported_key <= raw_key;
        end
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      result.reported <= report;
      result.code     <= report ? raw_key : KEY_NONE;
    end
  end

endmodule

`default_nettype wire

/* rtl/kpd_checker.sv */
// ---------------------------------------------------------------------------
// kpd_checker
// Port-level assertions for keypad_scan_debounce, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kpd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tuser
);

  `ASSERT_ALWAYS(a_reset_clears_valid, clk, rst |=> !m_tvalid)

  `ASSERT_CLK(a_stall_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  `ASSERT_CLK(a_report_has_key, clk, rst, m_tvalid && m_tuser |-> m_tdata[4:0] != 5'd0 && m_tdata <= 8'd16)

  `ASSERT_CLK(a_idle_code_none, clk, rst, m_tvalid && !m_tuser |-> m_tdata == 8'd0)

endmodule

bind keypad_scan_debounce kpd_checker u_kpd_checker (.*);

`default_nettype wire
